>>> rtl/sorted_table_insert_find_unit_assert.svh
// Assertion macros used by the checker file of the sorted table unit
`ifndef SORTED_TABLE_INSERT_FIND_UNIT_ASSERT_SVH
`define SORTED_TABLE_INSERT_FIND_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define STIF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define STIF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/stif_pkg.sv
// Shared types, constants and encoders of the sorted table unit
package stif_pkg;

  localparam int DEPTH     = 256;
  localparam int ITEM_BITS = 32;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int GRP       = 16;
  localparam int NGRP      = DEPTH / GRP;
  localparam int GRP_W     = $clog2(GRP);
  localparam int NGRP_W    = $clog2(NGRP);

  localparam int IN_W  = 48;
  localparam int OUT_W = 56;

  typedef logic [ITEM_BITS-1:0] word_t;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_FIND  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_CLEAR = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_RED1,
    S_RED2,
    S_FIN
  } state_t;

  typedef struct packed {
    logic             cmp;
    logic             wr;
    logic [IDX_W-1:0] pos;
    logic [CNT_W-1:0] cnt;
    word_t            word;
  } cell_ctl_t;

  typedef struct packed {
    logic             ge_any;
    logic [IDX_W-1:0] ge_pos;
    logic             eq_any;
    logic [IDX_W-1:0] eq_pos;
    word_t            rd_word;
  } loc_t;

  function automatic logic [GRP_W-1:0] first_in_grp(input logic [GRP-1:0] v);
    logic [GRP_W-1:0] r;
    r = '0;
    for (int k = GRP - 1; k >= 0; k--) begin
      if (v[k]) r = GRP_W'(k);
    end
    return r;
  endfunction

  function automatic logic [NGRP_W-1:0] first_grp(input logic [NGRP-1:0] v);
    logic [NGRP_W-1:0] r;
    r = '0;
    for (int k = NGRP - 1; k >= 0; k--) begin
      if (v[k]) r = NGRP_W'(k);
    end
    return r;
  endfunction

endpackage

>>> rtl/stif_cell.sv
// One table cell: holds an entry, compares it, loads or shifts from its neighbor
module stif_cell
  import stif_pkg::*;
(
  input  logic             clk,
  input  logic [IDX_W-1:0] cell_idx,
  input  cell_ctl_t        ctl,
  input  word_t            prev_entry,
  output word_t            entry,
  output logic             ge,
  output logic             eq
);

  word_t entry_r;
  logic  ge_r;
  logic  eq_r;
  logic  in_use;
  logic  shift_en;

  assign in_use   = {1'b0, cell_idx} < ctl.cnt;
  assign shift_en = (cell_idx > ctl.pos) && ({1'b0, cell_idx} <= ctl.cnt);

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      ge_r <= in_use && (entry_r >= ctl.word);
      eq_r <= in_use && (entry_r == ctl.word);
    end
    if (ctl.wr) begin
      if (cell_idx == ctl.pos) begin
        entry_r <= ctl.word;
      end else if (shift_en) begin
        entry_r <= prev_entry;
      end
    end
  end

  assign entry = entry_r;
  assign ge    = ge_r;
  assign eq    = eq_r;

endmodule

>>> rtl/stif_locate.sv
// Two-stage registered reduction: first match positions and indexed read
module stif_locate
  import stif_pkg::*;
(
  input  logic             clk,
  input  logic [DEPTH-1:0] ge_vec,
  input  logic [DEPTH-1:0] eq_vec,
  input  word_t            entries [DEPTH],
  input  logic [IDX_W-1:0] ridx,
  output loc_t             loc
);

  logic [NGRP-1:0]  ge_any1_r;
  logic [NGRP-1:0]  eq_any1_r;
  logic [GRP_W-1:0] ge_lo1_r [NGRP];
  logic [GRP_W-1:0] eq_lo1_r [NGRP];
  word_t            rd1_r    [NGRP];
  loc_t             loc_r;
  loc_t             loc_nxt;
  logic [NGRP_W-1:0] ge_g;
  logic [NGRP_W-1:0] eq_g;

  always_ff @(posedge clk) begin
    for (int g = 0; g < NGRP; g++) begin
      ge_any1_r[g] <= |ge_vec[g*GRP +: GRP];
      eq_any1_r[g] <= |eq_vec[g*GRP +: GRP];
      ge_lo1_r[g]  <= first_in_grp(ge_vec[g*GRP +: GRP]);
      eq_lo1_r[g]  <= first_in_grp(eq_vec[g*GRP +: GRP]);
      rd1_r[g]     <= entries[g*GRP + int'(ridx[GRP_W-1:0])];
    end
  end

  always_comb begin
    ge_g            = first_grp(ge_any1_r);
    eq_g            = first_grp(eq_any1_r);
    loc_nxt.ge_any  = |ge_any1_r;
    loc_nxt.eq_any  = |eq_any1_r;
    loc_nxt.ge_pos  = {ge_g, ge_lo1_r[ge_g]};
    loc_nxt.eq_pos  = {eq_g, eq_lo1_r[eq_g]};
    loc_nxt.rd_word = rd1_r[ridx[IDX_W-1:GRP_W]];
  end

  always_ff @(posedge clk) begin
    loc_r <= loc_nxt;
  end

  assign loc = loc_r;

endmodule

>>> rtl/sorted_table_insert_find_unit.sv
// Top level of the sorted table unit: request sequencer, cell row, result register
//
// Requests arrive on the in_ stream (in_tvalid/in_tready/in_tdata), one item
// per table action: add, find, read at index or clear. Each accepted item
// gives exactly one result item on the out_ stream.
// After an item is accepted, it is compared in all cells, goes through two
// reduction stages of the first-match search, and then its result is written
// back and loaded into the output register. The next item is taken at the
// earliest in the cycle after the result is loaded, so one is in work at a time.
// in_tready is high only while the sequencer waits for a request.
// A finished result waits in the output register; the next request is taken
// and worked on meanwhile, and its write-back waits until the register frees.
// cfg_wr_en/cfg_wr_data set the sorted mode bit; write it only while idle.
// Reset (rst_n low, synchronous) empties the table and sets sorted mode.
// Table contents are not cleared; only positions below the count are seen.
module sorted_table_insert_find_unit
  import stif_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // action[1:0], item_word[33:2], read_index[41:34]
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // status[1:0], found_index[9:2],
                                       // read_word[41:10], entry_count[50:42]
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data
);

  state_t           state_r, state_nxt;
  act_t             act_r;
  word_t            word_r;
  logic [7:0]       ridx_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             sorted_r;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  logic             cmp_en;
  logic             fin_go;
  logic             do_wr;
  logic [IDX_W-1:0] wr_pos;
  cell_ctl_t        ctl;
  loc_t             loc;

  stat_t            res_stat;
  logic [7:0]       res_idx;
  word_t            res_word;

  word_t            entries [DEPTH];
  logic [DEPTH-1:0] ge_vec;
  logic [DEPTH-1:0] eq_vec;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_CMP;
      S_CMP:   state_nxt = S_RED1;
      S_RED1:  state_nxt = S_RED2;
      S_RED2:  state_nxt = S_FIN;
      S_FIN:   if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmp_en    = 1'b0;
    fin_go    = 1'b0;
    unique case (state_r)
      S_IDLE:  in_tready = 1'b1;
      S_CMP:   cmp_en = 1'b1;
      S_FIN:   fin_go = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      act_r  <= act_t'(in_tdata[1:0]);
      word_r <= in_tdata[33:2];
      ridx_r <= in_tdata[41:34];
    end
  end

  // result and count update
  always_comb begin
    res_stat = ST_OK;
    res_idx  = '0;
    res_word = '0;
    cnt_nxt  = cnt_r;
    do_wr    = 1'b0;
    wr_pos   = cnt_r[IDX_W-1:0];
    case (act_r)
      ACT_ADD: begin
        if (cnt_r == CNT_W'(DEPTH)) begin
          res_stat = ST_FULL;
        end else begin
          if (sorted_r && loc.ge_any) wr_pos = loc.ge_pos;
          res_idx = 8'(wr_pos);
          cnt_nxt = cnt_r + 1'b1;
          do_wr   = 1'b1;
        end
      end
      ACT_FIND: begin
        if (loc.eq_any) begin
          res_idx = 8'(loc.eq_pos);
        end else begin
          res_stat = ST_NOT_FOUND;
        end
      end
      ACT_READ: begin
        if (CNT_W'(ridx_r) < cnt_r) begin
          res_word = loc.rd_word;
        end else begin
          res_stat = ST_RANGE;
        end
      end
      default: cnt_nxt = '0;
    endcase
    out_data_nxt = {5'd0, 9'(cnt_nxt), res_word, res_idx, res_stat};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      sorted_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) sorted_r <= cfg_wr_data;
      if (fin_go) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign ctl.cmp  = cmp_en;
  assign ctl.wr   = fin_go && do_wr;
  assign ctl.pos  = wr_pos;
  assign ctl.cnt  = cnt_r;
  assign ctl.word = word_r;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t prev;
    if (i == 0) begin : g_head
      assign prev = '0;
    end else begin : g_body
      assign prev = entries[i-1];
    end
    stif_cell u_cell (
      .clk        (clk),
      .cell_idx   (IDX_W'(i)),
      .ctl        (ctl),
      .prev_entry (prev),
      .entry      (entries[i]),
      .ge         (ge_vec[i]),
      .eq         (eq_vec[i])
    );
  end

  stif_locate u_locate (
    .clk     (clk),
    .ge_vec  (ge_vec),
    .eq_vec  (eq_vec),
    .entries (entries),
    .ridx    (IDX_W'(ridx_r)),
    .loc     (loc)
  );

endmodule

>>> rtl/stif_checker.sv
// Port-level checker of the sorted table unit and its bind
`include "sorted_table_insert_find_unit_assert.svh"

module stif_checker
  import stif_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  `STIF_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result item changed")
  `STIF_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "request taken while one is in work")
  `STIF_ASSERT_NOW(a_full_count, out_tvalid && out_tdata[1:0] == ST_FULL, out_tdata[50:42] == 9'(DEPTH) && out_tdata[9:2] == 8'd0, "full status with table not full")
  `STIF_ASSERT_NOW(a_range_zero, out_tvalid && out_tdata[1:0] == ST_RANGE, out_tdata[41:10] == '0, "out of range read gave a word")

endmodule

bind sorted_table_insert_find_unit stif_checker u_stif_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
